>>> hw/rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ============================================================================
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_FREQ_BITS   = 24;

    localparam int SYM_W   = 8;
    localparam int TAG_W   = 9;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new key
// and shifts right on insert or left on pop.
// ============================================================================
module spq_cell #(
    parameter int INDEX       = 0,
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int FREQ_BITS   = spq_pkg::DEF_FREQ_BITS
) (
    input  logic                               i_clk,
    input  spq_pkg::t_cell_ctrl                i_ctrl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_count,
    input  logic [FREQ_BITS-1:0]               i_new_freq,
    input  logic [spq_pkg::SYM_W-1:0]          i_new_symbol,
    input  logic [spq_pkg::TAG_W-1:0]          i_new_tag,
    input  logic                               i_left_after,
    input  logic [FREQ_BITS-1:0]               i_left_freq,
    input  logic [spq_pkg::SYM_W-1:0]          i_left_symbol,
    input  logic [spq_pkg::TAG_W-1:0]          i_left_tag,
    input  logic [FREQ_BITS-1:0]               i_right_freq,
    input  logic [spq_pkg::SYM_W-1:0]          i_right_symbol,
    input  logic [spq_pkg::TAG_W-1:0]          i_right_tag,
    output logic                               o_after,
    output logic [FREQ_BITS-1:0]               o_freq,
    output logic [spq_pkg::SYM_W-1:0]          o_symbol,
    output logic [spq_pkg::TAG_W-1:0]          o_tag
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [FREQ_BITS-1:0] r_freq;
    logic [SYM_W-1:0]     r_symbol;
    logic [TAG_W-1:0]     r_tag;
    logic                 w_occupied;
    logic                 w_key_after;

    assign w_occupied  = i_count > CNT_W'(INDEX);
    assign w_key_after = (r_freq != i_new_freq) ? (r_freq > i_new_freq)
                                                : (r_symbol > i_new_symbol);
    // free slots count as "after" so the new entry lands at the tail
    assign o_after  = !w_occupied || w_key_after;
    assign o_freq   = r_freq;
    assign o_symbol = r_symbol;
    assign o_tag    = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && o_after) begin
            if (i_left_after) begin
                r_freq   <= i_left_freq;
                r_symbol <= i_left_symbol;
                r_tag    <= i_left_tag;
            end else begin
                r_freq   <= i_new_freq;
                r_symbol <= i_new_symbol;
                r_tag    <= i_new_tag;
            end
        end else if (i_ctrl.pop) begin
            r_freq   <= i_right_freq;
            r_symbol <= i_right_symbol;
            r_tag    <= i_right_tag;
        end
    end

endmodule

>>> hw/rtl/sorted_priority_queue_unit.sv
// ============================================================================
// sorted_priority_queue_unit
// Sorted priority queue for tree building: a chain of cells kept in
// ascending (frequency, symbol) order; insert places an entry, pop removes
// the head, and each transaction returns one result.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  kind, item_freq, item_symbol, item_tag
//   result   out        o_valid / i_stall  popped_*, head_*, entry_count, status
//
// One transaction per cycle while o_stall is low: each cell compares its key with
// the new one in parallel and shifts in the same cycle; the result is registered.
// An output register and a skid register follow the chain; the input stalls
// only while the skid register is full.
// Reset clears the count and the result valids; cell contents are not reset.
// ============================================================================
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int FREQ_BITS   = spq_pkg::DEF_FREQ_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [FREQ_BITS-1:0]          i_item_freq,
    input  logic [spq_pkg::SYM_W-1:0]     i_item_symbol,
    input  logic [spq_pkg::TAG_W-1:0]     i_item_tag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [FREQ_BITS-1:0]          o_popped_freq,
    output logic [spq_pkg::SYM_W-1:0]     o_popped_symbol,
    output logic [spq_pkg::TAG_W-1:0]     o_popped_tag,
    output logic [FREQ_BITS-1:0]          o_head_freq,
    output logic [spq_pkg::SYM_W-1:0]     o_head_symbol,
    output logic [spq_pkg::TAG_W-1:0]     o_head_tag,
    output logic [spq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic [spq_pkg::STAT_W-1:0]    o_status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FREQ_BITS-1:0] popped_freq;
        logic [SYM_W-1:0]     popped_symbol;
        logic [TAG_W-1:0]     popped_tag;
        logic [FREQ_BITS-1:0] head_freq;
        logic [SYM_W-1:0]     head_symbol;
        logic [TAG_W-1:0]     head_tag;
        logic [COUNT_W-1:0]   entry_count;
        logic [STAT_W-1:0]    status;
    } t_result;

    logic [FREQ_BITS-1:0] w_freq   [QUEUE_DEPTH];
    logic [SYM_W-1:0]     w_symbol [QUEUE_DEPTH];
    logic [TAG_W-1:0]     w_tag    [QUEUE_DEPTH];
    logic                 w_after  [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;
    t_result          r_out;
    t_result          r_skid;
    t_result          w_res;
    t_cell_ctrl       w_ctrl;
    logic             w_acc;
    logic             w_take;
    logic             w_full;
    logic             w_empty;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    assign w_acc   = i_valid && !r_skid_valid;
    assign w_take  = r_out_valid && !i_stall;
    assign w_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign w_empty = r_count == '0;
    assign o_stall = r_skid_valid;

    assign w_ctrl.ins = w_acc && (i_kind == KIND_INSERT) && !w_full;
    assign w_ctrl.pop = w_acc && (i_kind == KIND_POP) && !w_empty;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            logic                 w_l_after;
            logic [FREQ_BITS-1:0] w_l_freq;
            logic [SYM_W-1:0]     w_l_symbol;
            logic [TAG_W-1:0]     w_l_tag;
            logic [FREQ_BITS-1:0] w_r_freq;
            logic [SYM_W-1:0]     w_r_symbol;
            logic [TAG_W-1:0]     w_r_tag;

            if (k == 0) begin : g_first
                assign w_l_after  = 1'b0;
                assign w_l_freq   = '0;
                assign w_l_symbol = '0;
                assign w_l_tag    = '0;
            end else begin : g_mid_l
                assign w_l_after  = w_after[k-1];
                assign w_l_freq   = w_freq[k-1];
                assign w_l_symbol = w_symbol[k-1];
                assign w_l_tag    = w_tag[k-1];
            end

            if (k == QUEUE_DEPTH - 1) begin : g_last
                assign w_r_freq   = w_freq[k];
                assign w_r_symbol = w_symbol[k];
                assign w_r_tag    = w_tag[k];
            end else begin : g_mid_r
                assign w_r_freq   = w_freq[k+1];
                assign w_r_symbol = w_symbol[k+1];
                assign w_r_tag    = w_tag[k+1];
            end

            spq_cell #(
                .INDEX      (k),
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .FREQ_BITS  (FREQ_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_count       (r_count),
                .i_new_freq    (i_item_freq),
                .i_new_symbol  (i_item_symbol),
                .i_new_tag     (i_item_tag),
                .i_left_after  (w_l_after),
                .i_left_freq   (w_l_freq),
                .i_left_symbol (w_l_symbol),
                .i_left_tag    (w_l_tag),
                .i_right_freq  (w_r_freq),
                .i_right_symbol(w_r_symbol),
                .i_right_tag   (w_r_tag),
                .o_after       (w_after[k]),
                .o_freq        (w_freq[k]),
                .o_symbol      (w_symbol[k]),
                .o_tag         (w_tag[k])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    always_comb begin
        w_res               = '0;
        w_res.entry_count   = w_count_ext[COUNT_W-1:0];
        w_res.status        = STATUS_OK;
        if (!w_empty) begin
            w_res.head_freq   = w_freq[0];
            w_res.head_symbol = w_symbol[0];
            w_res.head_tag    = w_tag[0];
        end
        if (i_kind == KIND_INSERT) begin
            if (w_full) begin
                w_res.status = STATUS_FULL;
            end else if (w_after[0]) begin
                w_res.head_freq   = i_item_freq;
                w_res.head_symbol = i_item_symbol;
                w_res.head_tag    = i_item_tag;
            end
        end else begin
            if (w_empty) begin
                w_res.status = STATUS_EMPTY;
            end else begin
                w_res.popped_freq   = w_freq[0];
                w_res.popped_symbol = w_symbol[0];
                w_res.popped_tag    = w_tag[0];
                if (r_count > CNT_W'(1)) begin
                    w_res.head_freq   = w_freq[1];
                    w_res.head_symbol = w_symbol[1];
                    w_res.head_tag    = w_tag[1];
                end else begin
                    w_res.head_freq   = '0;
                    w_res.head_symbol = '0;
                    w_res.head_tag    = '0;
                end
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_acc) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_popped_freq   = r_out.popped_freq;
    assign o_popped_symbol = r_out.popped_symbol;
    assign o_popped_tag    = r_out.popped_tag;
    assign o_head_freq     = r_out.head_freq;
    assign o_head_symbol   = r_out.head_symbol;
    assign o_head_tag      = r_out.head_tag;
    assign o_entry_count   = r_out.entry_count;
    assign o_status        = r_out.status;

endmodule
